### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on aclk and off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### src/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// types, codes and field limits shared by the cron schedule matcher
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] MARK_NONE   = 3'b000;
    localparam logic [2:0] MARK_STAR   = 3'b001;
    localparam logic [2:0] MARK_HYPHEN = 3'b010;
    localparam logic [2:0] MARK_SLASH  = 3'b100;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_DIGITS = 3'd1;
    localparam logic [2:0] ERR_SYNTAX = 3'd2;
    localparam logic [2:0] ERR_STEP   = 3'd3;
    localparam logic [2:0] ERR_COUNT  = 3'd4;

    localparam logic [2:0] NUM_FIELDS = 3'd5;
    localparam logic [2:0] FIELD_SAT  = 3'd7;
    localparam logic [2:0] DIV_STEPS  = 3'd6;

    typedef struct packed {
        logic load;
        logic do_char;
        logic term_eval;
        logic div_step;
        logic div_apply;
        logic end_field;
        logic clear_all;
    } csm_cmd_t;

    typedef struct packed {
        logic term_req;
        logic is_space;
        logic last;
        logic need_div;
        logic div_done;
        logic err_zero;
    } csm_status_t;

    function automatic logic [6:0] lim_lo(input logic [2:0] idx);
        logic [6:0] v;
        case (idx)
            3'd2:    v = 7'd1;
            3'd3:    v = 7'd1;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] lim_hi(input logic [2:0] idx);
        logic [6:0] v;
        case (idx)
            3'd0:    v = 7'd59;
            3'd1:    v = 7'd23;
            3'd2:    v = 7'd31;
            3'd3:    v = 7'd12;
            default: v = 7'd6;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/csm_dpath.sv
// ----------------------------------------------------------------------------
// csm_dpath
// parse registers, term evaluation and bit-serial step remainder
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module csm_dpath import csm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_last,
    input  wire logic [5:0]  s_minute,
    input  wire logic [4:0]  s_hour,
    input  wire logic [4:0]  s_mday,
    input  wire logic [3:0]  s_month,
    input  wire logic [2:0]  s_wday,
    input  wire csm_cmd_t    cmd,
    output csm_status_t      st,
    output logic             m_fire,
    output logic [2:0]       m_error_code
);

    // captured item
    logic [7:0] ch_reg,     ch_next;
    logic       last_reg,   last_next;
    logic [5:0] minute_reg, minute_next;
    logic [4:0] hour_reg,   hour_next;
    logic [4:0] mday_reg,   mday_next;
    logic [3:0] month_reg,  month_next;
    logic [2:0] wday_reg,   wday_next;

    // parse state
    logic [2:0] field_index_reg,  field_index_next;
    logic [2:0] term_marks_reg,   term_marks_next;
    logic [6:0] first_value_reg,  first_value_next;
    logic [6:0] second_value_reg, second_value_next;
    logic [6:0] number_acc_reg,   number_acc_next;
    logic [1:0] digit_count_reg,  digit_count_next;
    logic       field_hit_reg,    field_hit_next;
    logic       all_hit_reg,      all_hit_next;
    logic [2:0] error_state_reg,  error_state_next;

    // step remainder unit
    logic [6:0] div_rem_reg, div_rem_next;
    logic [5:0] div_dvd_reg, div_dvd_next;
    logic [2:0] div_cnt_reg, div_cnt_next;

    logic       valid_field;
    logic [2:0] idx;
    logic [5:0] cur;
    logic [6:0] cur7;
    logic       has_digits;
    logic       is_single, is_star, is_range, is_hstep, is_sstep, is_step;
    logic [6:0] step_lo, step_hi;
    logic       in_rng;
    logic [6:0] dvd_full;
    logic       hit_now;
    logic [2:0] term_err;
    logic       need_div;
    logic       is_digit;
    logic [3:0] dig;
    logic [6:0] acc_x10;
    logic [7:0] rem_sh;
    logic [7:0] div_s;
    logic [2:0] code;

    assign valid_field = (field_index_reg < NUM_FIELDS);
    assign idx         = valid_field ? field_index_reg : 3'd0;

    always_comb begin
        case (idx)
            3'd0:    cur = minute_reg;
            3'd1:    cur = {1'b0, hour_reg};
            3'd2:    cur = {1'b0, mday_reg};
            3'd3:    cur = {2'b00, month_reg};
            default: cur = {3'b000, wday_reg};
        endcase
    end

    assign cur7       = {1'b0, cur};
    assign has_digits = (digit_count_reg != 2'd0);
    assign is_single  = (term_marks_reg == MARK_NONE) && has_digits;
    assign is_star    = (term_marks_reg == MARK_STAR) && !has_digits;
    assign is_range   = (term_marks_reg == MARK_HYPHEN) && has_digits;
    assign is_hstep   = (term_marks_reg == (MARK_HYPHEN | MARK_SLASH)) && has_digits;
    assign is_sstep   = (term_marks_reg == (MARK_STAR | MARK_SLASH)) && has_digits;
    assign is_step    = is_hstep || is_sstep;

    assign step_lo  = is_hstep ? first_value_reg  : lim_lo(idx);
    assign step_hi  = is_hstep ? second_value_reg : lim_hi(idx);
    assign in_rng   = (cur7 >= step_lo) && (cur7 <= step_hi);
    assign dvd_full = cur7 - step_lo;

    always_comb begin
        hit_now  = 1'b0;
        term_err = ERR_NONE;
        if (is_single) begin
            hit_now = (cur7 == number_acc_reg);
        end else if (is_star) begin
            hit_now = 1'b1;
        end else if (is_range) begin
            hit_now = (cur7 >= first_value_reg) && (cur7 <= number_acc_reg);
        end else if (is_step) begin
            if (number_acc_reg == 7'd0) begin
                term_err = ERR_STEP;
            end
        end else begin
            term_err = ERR_SYNTAX;
        end
    end

    // stepped terms inside their range wait for the remainder
    assign need_div = is_step && (number_acc_reg != 7'd0) && in_rng;

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign dig      = 4'(ch_reg - CH_ZERO);
    assign acc_x10  = {number_acc_reg[3:0], 3'b000} + {number_acc_reg[5:0], 1'b0}
                      + {3'b000, dig};

    assign rem_sh = {div_rem_reg, div_dvd_reg[5]};
    assign div_s  = {1'b0, number_acc_reg};

    always_comb begin
        ch_next           = ch_reg;
        last_next         = last_reg;
        minute_next       = minute_reg;
        hour_next         = hour_reg;
        mday_next         = mday_reg;
        month_next        = month_reg;
        wday_next         = wday_reg;
        field_index_next  = field_index_reg;
        term_marks_next   = term_marks_reg;
        first_value_next  = first_value_reg;
        second_value_next = second_value_reg;
        number_acc_next   = number_acc_reg;
        digit_count_next  = digit_count_reg;
        field_hit_next    = field_hit_reg;
        all_hit_next      = all_hit_reg;
        error_state_next  = error_state_reg;
        div_rem_next      = div_rem_reg;
        div_dvd_next      = div_dvd_reg;
        div_cnt_next      = div_cnt_reg;

        if (cmd.load) begin
            ch_next     = s_ch;
            last_next   = s_last;
            minute_next = s_minute;
            hour_next   = s_hour;
            mday_next   = s_mday;
            month_next  = s_month;
            wday_next   = s_wday;
        end

        if (cmd.do_char && (error_state_reg == ERR_NONE)) begin
            if (is_digit) begin
                if (term_marks_reg == MARK_STAR) begin
                    error_state_next = ERR_SYNTAX;
                end else if (digit_count_reg >= 2'd2) begin
                    error_state_next = ERR_DIGITS;
                end else begin
                    number_acc_next  = acc_x10;
                    digit_count_next = digit_count_reg + 2'd1;
                end
            end else if (ch_reg == CH_STAR) begin
                if ((term_marks_reg != MARK_NONE) || has_digits) begin
                    error_state_next = ERR_SYNTAX;
                end else begin
                    term_marks_next = MARK_STAR;
                end
            end else if (ch_reg == CH_HYPHEN) begin
                if ((term_marks_reg == MARK_NONE) && has_digits) begin
                    first_value_next = number_acc_reg;
                    number_acc_next  = 7'd0;
                    digit_count_next = 2'd0;
                    term_marks_next  = MARK_HYPHEN;
                end else begin
                    error_state_next = ERR_SYNTAX;
                end
            end else if (ch_reg == CH_SLASH) begin
                if ((term_marks_reg == MARK_STAR) && !has_digits) begin
                    term_marks_next = term_marks_reg | MARK_SLASH;
                end else if ((term_marks_reg == MARK_HYPHEN) && has_digits) begin
                    second_value_next = number_acc_reg;
                    number_acc_next   = 7'd0;
                    digit_count_next  = 2'd0;
                    term_marks_next   = term_marks_reg | MARK_SLASH;
                end else begin
                    error_state_next = ERR_SYNTAX;
                end
            end else if ((ch_reg != CH_COMMA) && (ch_reg != CH_SPACE)) begin
                error_state_next = ERR_SYNTAX;
            end
        end

        if (cmd.term_eval) begin
            if (need_div) begin
                div_rem_next = 7'd0;
                div_dvd_next = dvd_full[5:0];
                div_cnt_next = DIV_STEPS;
            end else begin
                if ((term_err != ERR_NONE) && (error_state_reg == ERR_NONE)) begin
                    error_state_next = term_err;
                end
                if (hit_now && valid_field) begin
                    field_hit_next = 1'b1;
                end
                term_marks_next   = MARK_NONE;
                first_value_next  = 7'd0;
                second_value_next = 7'd0;
                number_acc_next   = 7'd0;
                digit_count_next  = 2'd0;
            end
        end

        // restoring remainder, one dividend bit a cycle
        if (cmd.div_step) begin
            if (rem_sh >= div_s) begin
                div_rem_next = 7'(rem_sh - div_s);
            end else begin
                div_rem_next = rem_sh[6:0];
            end
            div_dvd_next = {div_dvd_reg[4:0], 1'b0};
            div_cnt_next = div_cnt_reg - 3'd1;
        end

        if (cmd.div_apply) begin
            if ((div_rem_reg == 7'd0) && valid_field) begin
                field_hit_next = 1'b1;
            end
            term_marks_next   = MARK_NONE;
            first_value_next  = 7'd0;
            second_value_next = 7'd0;
            number_acc_next   = 7'd0;
            digit_count_next  = 2'd0;
        end

        if (cmd.end_field) begin
            all_hit_next   = all_hit_reg & field_hit_reg;
            field_hit_next = 1'b0;
            if (field_index_reg < FIELD_SAT) begin
                field_index_next = field_index_reg + 3'd1;
            end
        end

        if (cmd.clear_all) begin
            field_index_next  = 3'd0;
            term_marks_next   = MARK_NONE;
            first_value_next  = 7'd0;
            second_value_next = 7'd0;
            number_acc_next   = 7'd0;
            digit_count_next  = 2'd0;
            field_hit_next    = 1'b0;
            all_hit_next      = 1'b1;
            error_state_next  = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg  <= 3'd0;
            term_marks_reg   <= MARK_NONE;
            first_value_reg  <= 7'd0;
            second_value_reg <= 7'd0;
            number_acc_reg   <= 7'd0;
            digit_count_reg  <= 2'd0;
            field_hit_reg    <= 1'b0;
            all_hit_reg      <= 1'b1;
            error_state_reg  <= ERR_NONE;
            div_cnt_reg      <= 3'd0;
        end else begin
            field_index_reg  <= field_index_next;
            term_marks_reg   <= term_marks_next;
            first_value_reg  <= first_value_next;
            second_value_reg <= second_value_next;
            number_acc_reg   <= number_acc_next;
            digit_count_reg  <= digit_count_next;
            field_hit_reg    <= field_hit_next;
            all_hit_reg      <= all_hit_next;
            error_state_reg  <= error_state_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg      <= ch_next;
        last_reg    <= last_next;
        minute_reg  <= minute_next;
        hour_reg    <= hour_next;
        mday_reg    <= mday_next;
        month_reg   <= month_next;
        wday_reg    <= wday_next;
        div_rem_reg <= div_rem_next;
        div_dvd_reg <= div_dvd_next;
    end

    assign st.term_req = (error_state_reg == ERR_NONE)
                         && ((ch_reg == CH_COMMA) || (ch_reg == CH_SPACE));
    assign st.is_space = (ch_reg == CH_SPACE);
    assign st.last     = last_reg;
    assign st.need_div = need_div;
    assign st.div_done = (div_cnt_reg == 3'd0);
    assign st.err_zero = (error_state_reg == ERR_NONE);

    assign code = (error_state_reg != ERR_NONE) ? error_state_reg
                : ((field_index_reg != NUM_FIELDS) ? ERR_COUNT : ERR_NONE);
    assign m_fire       = (code == ERR_NONE) && all_hit_reg;
    assign m_error_code = code;

    // divisor must never be zero while the remainder runs
    `ASSERT_IMP(a_div_nonzero, div_cnt_reg != 3'd0, number_acc_reg != 7'd0)
    // first error wins until the schedule is closed
    `ASSERT_NXT(a_err_sticky, (error_state_reg != ERR_NONE) && !cmd.clear_all,
                error_state_reg == $past(error_state_reg))
    // field count saturates
    `ASSERT_NXT(a_field_sat, cmd.end_field && (field_index_reg == FIELD_SAT) && !cmd.clear_all,
                field_index_reg == FIELD_SAT)

endmodule

`default_nettype wire

### src/csm_ctrl.sv
// ----------------------------------------------------------------------------
// csm_ctrl
// sequencer for character decode, term close, remainder and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module csm_ctrl import csm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire csm_status_t st,
    output csm_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHAR  = 7'b0000010,
        ST_TERM  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_FIELD = 7'b0010000,
        ST_FINAL = 7'b0100000,
        ST_OUT   = 7'b1000000
    } csm_state_t;

    csm_state_t state_reg, state_next;
    logic       final_pass_reg, final_pass_next;
    csm_state_t after_term;

    // where to go once the current term is closed
    always_comb begin
        if (final_pass_reg || st.is_space) begin
            after_term = ST_FIELD;
        end else if (st.last) begin
            after_term = ST_FINAL;
        end else begin
            after_term = ST_IDLE;
        end
    end

    always_comb begin
        state_next      = state_reg;
        final_pass_next = final_pass_reg;
        cmd             = '0;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR: begin
                cmd.do_char = 1'b1;
                if (st.term_req) begin
                    state_next = ST_TERM;
                end else if (st.last) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TERM: begin
                cmd.term_eval = 1'b1;
                state_next    = st.need_div ? ST_DIV : after_term;
            end
            ST_DIV: begin
                if (st.div_done) begin
                    cmd.div_apply = 1'b1;
                    state_next    = after_term;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIELD: begin
                cmd.end_field = 1'b1;
                if (final_pass_reg) begin
                    state_next = ST_OUT;
                end else if (st.last) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (st.err_zero) begin
                    final_pass_next = 1'b1;
                    state_next      = ST_TERM;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.clear_all   = 1'b1;
                    final_pass_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next      = ST_IDLE;
                final_pass_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            final_pass_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            final_pass_reg <= final_pass_next;
        end
    end

    // the closing pass only runs for the final item of a schedule
    `ASSERT_IMP(a_final_on_last, final_pass_reg, st.last)
    // the remainder unit is only entered with a term that needs it
    `ASSERT_NXT(a_div_entry, (state_reg == ST_TERM) && st.need_div, !st.div_done)

endmodule

`default_nettype wire

### src/cron_schedule_matcher.sv
// ----------------------------------------------------------------------------
// cron_schedule_matcher
// checks one cron schedule, streamed a character per item, against a time
// ----------------------------------------------------------------------------
// One item carries a schedule character plus the current minute, hour, day,
// month and weekday; the item flagged s_last closes the schedule and yields
// one result (m_fire, m_error_code), all other items yield none. A plain
// character is decoded before the next item is accepted. A comma or space
// then closes a term, and a stepped term whose value is in range also
// passes through a restoring divider for the step remainder, which retires
// one dividend bit per cycle; a space then closes the field as well. Unless
// an error is already recorded, the last item adds the closing term and
// field before the result hand-off. Only one item is in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cron_schedule_matcher import csm_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_last,
    input  wire logic [5:0] s_minute,
    input  wire logic [4:0] s_hour,
    input  wire logic [4:0] s_mday,
    input  wire logic [3:0] s_month,
    input  wire logic [2:0] s_wday,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_fire,
    output logic [2:0]      m_error_code
);

    csm_cmd_t    cmd;
    csm_status_t st;

    csm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    csm_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_ch         (s_ch),
        .s_last       (s_last),
        .s_minute     (s_minute),
        .s_hour       (s_hour),
        .s_mday       (s_mday),
        .s_month      (s_month),
        .s_wday       (s_wday),
        .cmd          (cmd),
        .st           (st),
        .m_fire       (m_fire),
        .m_error_code (m_error_code)
    );

endmodule

`default_nettype wire

### tb/cron_schedule_matcher_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cron_schedule_matcher_checker
// Follows every item into the matcher and every result out of it. It keeps
// its own parse of the schedule being streamed, works out the verdict due on
// each closing item and compares the results in order, field by field.
// ---------------------------------------------------------------------------
module cron_schedule_matcher_checker import csm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_last,
    input  logic [5:0]  s_minute,
    input  logic [4:0]  s_hour,
    input  logic [4:0]  s_mday,
    input  logic [3:0]  s_month,
    input  logic [2:0]  s_wday,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_fire,
    input  logic [2:0]  m_error_code,
    output int unsigned verdicts_due,
    output int unsigned mismatches
);

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] mday;
        logic [3:0] month;
        logic [2:0] wday;
    } stamp_t;

    typedef struct packed {
        logic       fire;
        logic [2:0] code;
    } verdict_t;

    verdict_t    verdict_q[$];
    int unsigned errors = 0;

    logic [2:0] fields_done;
    logic [2:0] term_kind;
    logic [6:0] range_lo;
    logic [6:0] range_hi;
    logic [6:0] number;
    logic [1:0] digits;
    logic       field_match;
    logic       all_match;
    logic [2:0] fault;

    function automatic int unsigned field_floor(input logic [2:0] idx);
        return (idx == 3'd2 || idx == 3'd3) ? 1 : 0;
    endfunction

    function automatic int unsigned field_ceiling(input logic [2:0] idx);
        case (idx)
            3'd0:    return 59;
            3'd1:    return 23;
            3'd2:    return 31;
            3'd3:    return 12;
            default: return 6;
        endcase
    endfunction

    function automatic int unsigned stamp_field(input stamp_t st, input logic [2:0] idx);
        case (idx)
            3'd0:    return st.minute;
            3'd1:    return st.hour;
            3'd2:    return st.mday;
            3'd3:    return st.month;
            default: return st.wday;
        endcase
    endfunction

    function automatic logic on_step(input int unsigned cur, lo, hi, stride);
        return cur >= lo && cur <= hi && (cur - lo) % stride == 0;
    endfunction

    // only the first fault of a schedule is kept
    function automatic void note_fault(input logic [2:0] code);
        if (fault == ERR_NONE) begin
            fault = code;
        end
    endfunction

    function automatic void clear_term();
        term_kind = MARK_NONE;
        range_lo  = '0;
        range_hi  = '0;
        number    = '0;
        digits    = '0;
    endfunction

    function automatic void clear_schedule();
        fields_done = '0;
        clear_term();
        field_match = 1'b0;
        all_match   = 1'b1;
        fault       = ERR_NONE;
    endfunction

    function automatic void close_term(input stamp_t st);
        logic        in_field;
        logic [2:0]  idx;
        int unsigned cur;
        logic        hit;
        in_field = fields_done < NUM_FIELDS;
        // surplus fields still get parsed against the minute limits
        idx = in_field ? fields_done : 3'd0;
        cur = stamp_field(st, idx);
        hit = 1'b0;
        if (term_kind == MARK_NONE && digits != 0) begin
            hit = cur == number;
        end else if (term_kind == MARK_STAR && digits == 0) begin
            hit = 1'b1;
        end else if (term_kind == MARK_HYPHEN && digits != 0) begin
            hit = cur >= range_lo && cur <= number;
        end else if (term_kind == (MARK_HYPHEN | MARK_SLASH) && digits != 0) begin
            if (number == 0) begin
                note_fault(ERR_STEP);
            end else begin
                hit = on_step(cur, range_lo, range_hi, number);
            end
        end else if (term_kind == (MARK_STAR | MARK_SLASH) && digits != 0) begin
            if (number == 0) begin
                note_fault(ERR_STEP);
            end else begin
                hit = on_step(cur, field_floor(idx), field_ceiling(idx), number);
            end
        end else begin
            note_fault(ERR_SYNTAX);
        end
        if (hit && in_field) begin
            field_match = 1'b1;
        end
        clear_term();
    endfunction

    function automatic void close_field();
        all_match   = all_match & field_match;
        field_match = 1'b0;
        if (fields_done < FIELD_SAT) begin
            fields_done = fields_done + 1'b1;
        end
    endfunction

    // returns 1 when the item closes the schedule and a verdict is due
    function automatic logic parse_char(input logic [7:0] ch, input logic last,
                                        input stamp_t st, output verdict_t v);
        logic [2:0] code;
        v.fire = 1'b0;
        v.code = ERR_NONE;
        if (fault == ERR_NONE) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                if (term_kind == MARK_STAR) begin
                    note_fault(ERR_SYNTAX);
                end else if (digits >= 2) begin
                    note_fault(ERR_DIGITS);
                end else begin
                    number = 7'(number * 10 + (ch - CH_ZERO));
                    digits = digits + 1'b1;
                end
            end else if (ch == CH_STAR) begin
                if (term_kind != MARK_NONE || digits != 0) begin
                    note_fault(ERR_SYNTAX);
                end else begin
                    term_kind = MARK_STAR;
                end
            end else if (ch == CH_HYPHEN) begin
                if (term_kind == MARK_NONE && digits != 0) begin
                    range_lo  = number;
                    number    = '0;
                    digits    = '0;
                    term_kind = MARK_HYPHEN;
                end else begin
                    note_fault(ERR_SYNTAX);
                end
            end else if (ch == CH_SLASH) begin
                if (term_kind == MARK_STAR && digits == 0) begin
                    term_kind = term_kind | MARK_SLASH;
                end else if (term_kind == MARK_HYPHEN && digits != 0) begin
                    range_hi  = number;
                    number    = '0;
                    digits    = '0;
                    term_kind = term_kind | MARK_SLASH;
                end else begin
                    note_fault(ERR_SYNTAX);
                end
            end else if (ch == CH_COMMA) begin
                close_term(st);
            end else if (ch == CH_SPACE) begin
                close_term(st);
                close_field();
            end else begin
                note_fault(ERR_SYNTAX);
            end
        end
        if (!last) begin
            return 1'b0;
        end
        if (fault == ERR_NONE) begin
            close_term(st);
            close_field();
        end
        code = fault;
        if (code == ERR_NONE && fields_done != NUM_FIELDS) begin
            code = ERR_COUNT;
        end
        v.fire = code == ERR_NONE && all_match;
        v.code = code;
        clear_schedule();
        return 1'b1;
    endfunction

    function automatic void flag(input string what, input int unsigned want, got);
        if (errors < 10) begin
            $display("checker: %s expected %0d got %0d", what, want, got);
        end
        errors++;
    endfunction

    always @(posedge aclk) begin : watch
        stamp_t   st;
        verdict_t want;
        verdict_t seen;
        if (!aresetn) begin
            clear_schedule();
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen.fire = m_fire;
                seen.code = m_error_code;
                if (verdict_q.size() == 0) begin
                    flag("schedules awaiting a result", 1, 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (seen.code !== want.code) begin
                        flag("error_code", want.code, seen.code);
                    end
                    if (seen.fire !== want.fire) begin
                        flag("fire", want.fire, seen.fire);
                    end
                end
            end
            if (s_valid && s_ready) begin
                st.minute = s_minute;
                st.hour   = s_hour;
                st.mday   = s_mday;
                st.month  = s_month;
                st.wday   = s_wday;
                if (parse_char(s_ch, s_last, st, want)) begin
                    verdict_q.push_back(want);
                end
            end
        end
        verdicts_due <= verdict_q.size();
        mismatches   <= errors;
    end

endmodule

### tb/cron_schedule_matcher_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cron_schedule_matcher_test
// Streams cron schedules into the matcher one character per item: a directed
// set of edge cases first, then random schedules built mostly from valid
// terms with some corrupted. The input side runs in bursts, the result side
// stalls on a redrawn mask; the checker beside the block judges each result.
// ---------------------------------------------------------------------------
module cron_schedule_matcher_test;

    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch     = 8'h20;
    logic        s_last   = 1'b0;
    logic [5:0]  s_minute = '0;
    logic [4:0]  s_hour   = '0;
    logic [4:0]  s_mday   = 5'd1;
    logic [3:0]  s_month  = 4'd1;
    logic [2:0]  s_wday   = '0;
    logic        m_valid;
    logic        m_ready  = 1'b0;
    logic        m_fire;
    logic [2:0]  m_error_code;
    int unsigned verdicts_due;
    int unsigned mismatches;

    // time presented with the schedule being sent
    logic [5:0]  t_minute;
    logic [4:0]  t_hour;
    logic [4:0]  t_mday;
    logic [3:0]  t_month;
    logic [2:0]  t_wday;
    logic [7:0]  sched[$];

    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    int unsigned mask_age   = 0;
    logic [3:0]  mask_pos   = '0;
    int unsigned idle_run;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cron_schedule_matcher i_dut (.*);

    cron_schedule_matcher_checker i_checker (.*);

    // receiver follows a 16-bit mask that is redrawn every so often
    always @(posedge aclk) begin
        if (mask_age == 0) begin
            stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                       : 16'($urandom_range(1, 65535));
            mask_age   <= $urandom_range(20, 120);
        end else begin
            mask_age <= mask_age - 1;
        end
        mask_pos <= mask_pos + 1'b1;
        m_ready  <= stall_mask[mask_pos];
    end

    task automatic send_item(input logic [7:0] ch, input logic last);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
        s_valid  <= 1'b1;
        s_ch     <= ch;
        s_last   <= last;
        s_minute <= t_minute;
        s_hour   <= t_hour;
        s_mday   <= t_mday;
        s_month  <= t_month;
        s_wday   <= t_wday;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_schedule();
        for (int unsigned i = 0; i < sched.size(); i++) begin
            send_item(sched[i], i == sched.size() - 1);
        end
    endtask

    task automatic load_text(input string text);
        sched.delete();
        for (int i = 0; i < text.len(); i++) begin
            sched.push_back(text[i]);
        end
    endtask

    task automatic set_time(input int unsigned mi, hr, md, mo, wd);
        t_minute = 6'(mi);
        t_hour   = 5'(hr);
        t_mday   = 5'(md);
        t_month  = 4'(mo);
        t_wday   = 3'(wd);
    endtask

    // mostly a real time, now and then anything the port widths allow
    task automatic draw_time();
        logic wild;
        wild     = $urandom_range(0, 7) == 0;
        t_minute = 6'(wild ? $urandom_range(0, 63) : $urandom_range(0, 59));
        t_hour   = 5'(wild ? $urandom_range(0, 31) : $urandom_range(0, 23));
        t_mday   = 5'(wild ? $urandom_range(0, 31) : $urandom_range(1, 31));
        t_month  = 4'(wild ? $urandom_range(0, 15) : $urandom_range(1, 12));
        t_wday   = 3'(wild ? $urandom_range(0, 7)  : $urandom_range(0, 6));
    endtask

    function automatic int unsigned now_of(input int unsigned idx);
        case (idx)
            0:       return t_minute;
            1:       return t_hour;
            2:       return t_mday;
            3:       return t_month;
            default: return t_wday;
        endcase
    endfunction

    function automatic int unsigned low_of(input int unsigned idx);
        return (idx == 2 || idx == 3) ? 1 : 0;
    endfunction

    function automatic int unsigned high_of(input int unsigned idx);
        case (idx)
            0:       return 59;
            1:       return 23;
            2:       return 31;
            3:       return 12;
            default: return 6;
        endcase
    endfunction

    function automatic int unsigned pick_value(input int unsigned lo, hi, cur);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return cur;
            5:             return $urandom_range(0, 99);
            default:       return $urandom_range(lo, hi);
        endcase
    endfunction

    // occasional leading zero, rarely a third digit
    function automatic string num_text(input int unsigned v);
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
            return $sformatf("%03d", v);
        end
        if (pick < 5 && v < 10) begin
            return $sformatf("%02d", v);
        end
        return $sformatf("%0d", v);
    endfunction

    function automatic string term_text(input int unsigned idx);
        int unsigned lo;
        int unsigned hi;
        int unsigned cur;
        int unsigned a;
        int unsigned b;
        int unsigned stride;
        int unsigned pick;
        lo     = low_of(idx);
        hi     = high_of(idx);
        cur    = now_of(idx);
        pick   = $urandom_range(0, 19);
        stride = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
        if (pick < 3) begin
            return "*";
        end
        if (pick < 8) begin
            return num_text(pick_value(lo, hi, cur));
        end
        if (pick < 12) begin
            if ($urandom_range(0, 1)) begin
                a = cur - $urandom_range(0, cur);
                b = cur + $urandom_range(0, 10);
            end else begin
                a = $urandom_range(lo, hi);
                b = $urandom_range(lo, hi);
            end
            return {num_text(a), "-", num_text(b)};
        end
        if (pick < 16) begin
            // anchor the start so that the current value often lands on a step
            if (stride != 0 && $urandom_range(0, 1)) begin
                a = cur - stride * $urandom_range(0, cur / stride);
            end else begin
                a = $urandom_range(lo, hi);
            end
            b = a + $urandom_range(0, 40);
            if (b > 99) begin
                b = 99;
            end
            return {num_text(a), "-", num_text(b), "/", num_text(stride)};
        end
        if (pick < 19) begin
            if (stride != 0 && $urandom_range(0, 1)) begin
                stride = $urandom_range(1, hi - lo + 1);
            end
            return {"*/", num_text(stride)};
        end
        case ($urandom_range(0, 9))
            0:       return "";
            1:       return "5/2";
            2:       return "*3";
            3:       return "4-";
            4:       return "*-";
            5:       return "-7";
            6:       return "*/";
            7:       return "1-2-3";
            8:       return "2-9/";
            default: return "**";
        endcase
    endfunction

    function automatic string field_text(input int unsigned idx);
        string       text;
        int unsigned terms;
        terms = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        text  = term_text(idx);
        for (int unsigned i = 1; i < terms; i++) begin
            text = {text, ",", term_text(idx)};
        end
        return text;
    endfunction

    task automatic corrupt_schedule();
        int unsigned pos;
        pos = $urandom_range(0, sched.size() - 1);
        case ($urandom_range(0, 5))
            0: sched[pos] = 8'($urandom_range(0, 255));
            1: sched.insert(pos, 8'($urandom_range(0, 255)));
            2: sched.insert(pos, " ");
            3: sched.insert(pos, ",");
            4: begin
                if (sched.size() > 1) begin
                    sched.delete(pos);
                end
            end
            default: sched.push_back(" ");
        endcase
    endtask

    task automatic draw_schedule();
        string       text;
        int unsigned nfields;
        nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 5;
        draw_time();
        text = field_text(0);
        for (int unsigned f = 1; f < nfields; f++) begin
            text = {text, " ", field_text(f < 5 ? f : $urandom_range(0, 4))};
        end
        load_text(text);
        if (sched.size() != 0 && $urandom_range(0, 6) == 0) begin
            corrupt_schedule();
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        set_time(0, 0, 1, 1, 0);
        load_text("0 0 1 1 0");
        send_schedule();
        set_time(59, 23, 31, 12, 6);
        load_text("59 23 31 12 6");
        send_schedule();
        // values past the field limits only match an equal number
        set_time(63, 31, 0, 15, 7);
        load_text("63 31 0 15 7");
        send_schedule();
        load_text("*/1 * * * *");
        send_schedule();
        set_time(30, 12, 15, 6, 3);
        load_text("0-59/15,5 */6 1-31 2-12/2 0,3-6");
        send_schedule();
        load_text("5-3 * 9-1/2 * *");
        send_schedule();
        load_text("123 * * * *");
        send_schedule();
        load_text("*\t* * * *");
        send_schedule();
        load_text("*,,5 * * * *");
        send_schedule();
        load_text("5/2 * * * *");
        send_schedule();
        // first fault must win over the later ones
        load_text("*3 123 */0 * *");
        send_schedule();
        load_text("* * */0 1-5/0 *");
        send_schedule();
        load_text("* * * *");
        send_schedule();
        load_text("* * * * * 5");
        send_schedule();
        load_text(" * * * * *");
        send_schedule();
        load_text("* * ");
        sched.push_back(8'hAA);
        sched.push_back(8'h55);
        sched.push_back("*");
        send_schedule();
        load_text("*");
        send_schedule();

        while (items_sent < ITEM_TARGET) begin
            draw_schedule();
            send_schedule();
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && verdicts_due == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ends the run when neither channel moves for too long
    initial begin : watchdog
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("tb: failure");
        $finish;
    end

endmodule
